>>> src/mck_pkg.sv
package mck_pkg;

  localparam int unsigned CountBits = 16;
  localparam int unsigned DotBits   = 12;
  localparam int unsigned UnitBits  = 4;
  localparam int unsigned ProdBits  = DotBits + UnitBits;

  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [3:0] {
    PhIdle  = 4'b0001,
    PhMark  = 4'b0010,
    PhSpace = 4'b0100,
    PhGap   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic key_on;
    logic busy_res;
    logic dropped;
  } result_t;

  localparam logic [1:0] RegDotTicks   = 2'd0;
  localparam logic [1:0] RegDashUnits  = 2'd1;
  localparam logic [1:0] RegLetterGap  = 2'd2;
  localparam logic [1:0] RegWordGap    = 2'd3;

  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [5:0] DigitBase = 6'd26;

  // count in bits 7:5, pattern in bits 4:0, sent msb first, 1 is dash
  function automatic logic [7:0] code_rom(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      6'd0:  v = 8'h48;  6'd1:  v = 8'h90;  6'd2:  v = 8'h94;  6'd3:  v = 8'h70;
      6'd4:  v = 8'h20;  6'd5:  v = 8'h84;  6'd6:  v = 8'h78;  6'd7:  v = 8'h80;
      6'd8:  v = 8'h40;  6'd9:  v = 8'h8E;  6'd10: v = 8'h74;  6'd11: v = 8'h88;
      6'd12: v = 8'h58;  6'd13: v = 8'h50;  6'd14: v = 8'h7C;  6'd15: v = 8'h8C;
      6'd16: v = 8'h9A;  6'd17: v = 8'h68;  6'd18: v = 8'h60;  6'd19: v = 8'h30;
      6'd20: v = 8'h64;  6'd21: v = 8'h82;  6'd22: v = 8'h6C;  6'd23: v = 8'h92;
      6'd24: v = 8'h96;  6'd25: v = 8'h98;  6'd26: v = 8'hBF;  6'd27: v = 8'hAF;
      6'd28: v = 8'hA7;  6'd29: v = 8'hA3;  6'd30: v = 8'hA1;  6'd31: v = 8'hA0;
      6'd32: v = 8'hB0;  6'd33: v = 8'hB8;  6'd34: v = 8'hBC;  6'd35: v = 8'hBE;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // dot length times units, saturated to the tick counter width
  function automatic count_t dots_to_ticks(input logic [DotBits-1:0] dot,
                                           input logic [UnitBits-1:0] units);
    logic [DotBits-1:0]  d;
    logic [ProdBits-1:0] p;
    logic [ProdBits:0]   hi;
    d  = (dot == '0) ? DotBits'(1) : dot;
    p  = ProdBits'(d) * ProdBits'(units);
    hi = {1'b0, p} >> CountBits;
    if (hi != '0) begin
      return '1;
    end
    return count_t'(p);
  endfunction

endpackage

>>> src/morse_code_keyer.sv
// morse code keyer
// input channel (in_valid_i / in_stall_o): one request per item, cmd_i 0 is
// one timer tick, cmd_i 1 sends the ascii character on char_code_i.
// output channel (out_valid_o / out_stall_i): exactly one result per request,
// key level after that request, busy flag, and a drop flag for a character
// that arrived while a letter or gap was still being timed.
// each request is handled in the cycle it is accepted and its result is
// registered; one request is taken every cycle while in_stall_o is low.
// the single path is the dot_ticks by units multiply feeding the tick counter.
// a two-entry output stage (result register plus skid register) keeps the
// input open while one result waits; in_stall_o rises only once both hold
// results, and nothing is lost or repeated while the receiver stalls.
// reset puts the keyer idle with the key off, empties the output stage and
// loads the registers with dot_ticks 24, dash 3, letter gap 5, word gap 7.
// the apb port writes and reads the four registers at byte addresses 0, 4,
// 8 and 12 with no wait states.
module morse_code_keyer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        key_on_o,
  output logic        busy_res_o,
  output logic        dropped_o
);

  logic [mck_pkg::DotBits-1:0] dot_ticks_q;
  logic [2:0]                  dash_units_q;
  logic [2:0]                  letter_gap_q;
  logic [3:0]                  word_gap_q;

  mck_pkg::phase_e phase_q, phase_d;
  logic [4:0]      pattern_q, pattern_d;
  logic [2:0]      elements_q, elements_d;
  mck_pkg::count_t ticks_q, ticks_d, ticks_dec, ticks_prod;
  logic            key_q, key_d;

  logic                         in_acc;
  logic                         load_ticks;
  logic [mck_pkg::UnitBits-1:0] units_sel;
  logic                         drop;
  mck_pkg::result_t             res;

  logic             out_valid_q, skid_valid_q;
  mck_pkg::result_t out_q, skid_q;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // configuration
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ticks_q  <= 12'd24;
      dash_units_q <= 3'd3;
      letter_gap_q <= 3'd5;
      word_gap_q   <= 4'd7;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mck_pkg::RegDotTicks:  dot_ticks_q  <= pwdata[11:0];
        mck_pkg::RegDashUnits: dash_units_q <= pwdata[2:0];
        mck_pkg::RegLetterGap: letter_gap_q <= pwdata[2:0];
        mck_pkg::RegWordGap:   word_gap_q   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mck_pkg::RegDotTicks:  prdata = {20'd0, dot_ticks_q};
      mck_pkg::RegDashUnits: prdata = {29'd0, dash_units_q};
      mck_pkg::RegLetterGap: prdata = {29'd0, letter_gap_q};
      mck_pkg::RegWordGap:   prdata = {28'd0, word_gap_q};
      default:               prdata = '0;
    endcase
  end

  // keyer next state
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;

  always_comb begin
    logic [7:0]                   code;
    logic                         is_letter, is_digit, is_space;
    logic [5:0]                   rom_idx;
    logic [2:0]                   dash_eff;
    logic [2:0]                   lg_units;
    logic [3:0]                   wg_units;
    logic [4:0]                   pat;
    logic [2:0]                   el;
    logic                         start_el, start_gap;
    logic [mck_pkg::UnitBits-1:0] gap_units;

    is_letter = char_code_i inside {[8'h41:8'h5A]};
    is_digit  = char_code_i inside {[8'h30:8'h39]};
    is_space  = (char_code_i == 8'h20);
    rom_idx   = is_letter ? 6'(char_code_i - mck_pkg::CharA)
                          : 6'(char_code_i - mck_pkg::CharZero) + mck_pkg::DigitBase;
    code      = mck_pkg::code_rom(rom_idx);
    dash_eff  = (dash_units_q == '0) ? 3'd1 : dash_units_q;
    lg_units  = (letter_gap_q == '0) ? 3'd0 : letter_gap_q - 3'd1;
    wg_units  = (word_gap_q > {1'b0, letter_gap_q}) ? word_gap_q - {1'b0, letter_gap_q}
                                                     : 4'd0;
    ticks_dec = (ticks_q == '0) ? '0 : ticks_q - mck_pkg::count_t'(1);

    phase_d    = phase_q;
    pattern_d  = pattern_q;
    elements_d = elements_q;
    key_d      = key_q;
    load_ticks = 1'b0;
    units_sel  = '0;
    drop       = 1'b0;
    start_el   = 1'b0;
    start_gap  = 1'b0;
    gap_units  = '0;
    pat        = pattern_q;
    el         = elements_q;

    if (in_acc) begin
      if (cmd_i) begin
        if (phase_q != mck_pkg::PhIdle) begin
          drop = 1'b1;
        end else if (is_letter || is_digit) begin
          pat = code[4:0];
          el  = code[7:5];
          pattern_d  = pat;
          elements_d = el;
          if (el != '0) begin
            start_el = 1'b1;
          end else begin
            start_gap = 1'b1;
            gap_units = {1'b0, lg_units};
          end
        end else if (is_space) begin
          start_gap = 1'b1;
          gap_units = wg_units;
        end
      end else if (phase_q != mck_pkg::PhIdle) begin
        if (ticks_dec == '0) begin
          case (phase_q)
            mck_pkg::PhMark: begin
              key_d      = 1'b0;
              load_ticks = 1'b1;
              units_sel  = 4'd1;
              phase_d    = mck_pkg::PhSpace;
            end
            mck_pkg::PhSpace: begin
              if (elements_q != '0) begin
                start_el = 1'b1;
              end else begin
                start_gap = 1'b1;
                gap_units = {1'b0, lg_units};
              end
            end
            default: begin
              key_d   = 1'b0;
              phase_d = mck_pkg::PhIdle;
            end
          endcase
        end
      end

      if (start_el) begin
        units_sel  = pat[4] ? {1'b0, dash_eff} : 4'd1;
        pattern_d  = {pat[3:0], 1'b0};
        elements_d = el - 3'd1;
        key_d      = 1'b1;
        load_ticks = 1'b1;
        phase_d    = mck_pkg::PhMark;
      end
      if (start_gap) begin
        units_sel  = gap_units;
        key_d      = 1'b0;
        load_ticks = 1'b1;
        phase_d    = (gap_units == '0) ? mck_pkg::PhIdle : mck_pkg::PhGap;
      end
    end
  end

  assign ticks_prod = mck_pkg::dots_to_ticks(dot_ticks_q, units_sel);

  always_comb begin
    ticks_d = ticks_q;
    if (in_acc && (cmd_i || phase_q != mck_pkg::PhIdle)) begin
      ticks_d = load_ticks ? ticks_prod : (cmd_i ? ticks_q : ticks_dec);
    end
  end

  assign res.key_on   = key_d;
  assign res.busy_res = (phase_d != mck_pkg::PhIdle);
  assign res.dropped  = drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mck_pkg::PhIdle;
      pattern_q  <= '0;
      elements_q <= '0;
      ticks_q    <= '0;
      key_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pattern_q  <= pattern_d;
      elements_q <= elements_d;
      ticks_q    <= ticks_d;
      key_q      <= key_d;
    end
  end

  // output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_on_o    = out_q.key_on;
  assign busy_res_o  = out_q.busy_res;
  assign dropped_o   = out_q.dropped;

endmodule
